// ----- rtl/core/lkvt_pkg.sv -----
// Shared types and constants for the linear key/value table unit.
// No dependencies; every other file in this block imports it.
`default_nettype none

package lkvt_pkg;

   // Default sizing of the table, handed to the top level as parameter defaults.
   localparam int unsigned DEF_ENTRIES     = 16;
   localparam int unsigned DEF_VALUE_WIDTH = 32;

   // Fixed widths of the request and response fields.
   localparam int unsigned KEY_W    = 32;
   localparam int unsigned DATA_W   = 32;
   localparam int unsigned COUNT_W  = 5;

   typedef enum logic [1:0] {
      CMD_SET    = 2'd0,
      CMD_GET    = 2'd1,
      CMD_TAKE   = 2'd2,
      CMD_RENAME = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STS_DONE  = 2'd0,
      STS_MISS  = 2'd1,
      STS_FULL  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      FSM_IDLE,
      FSM_SCAN,
      FSM_EXEC,
      FSM_GET_VAL,
      FSM_TAKE_LAST,
      FSM_TAKE_MOVE,
      FSM_RESP
   } state_type;

endpackage

`default_nettype wire

// ----- rtl/core/lkvt_if.sv -----
// Request and response channel interfaces of the linear key/value table unit.
// Depends on lkvt_pkg for the command and status types.
`default_nettype none

interface lkvt_req_if;
   import lkvt_pkg::*;

   logic                     valid;
   logic                     ready;
   cmd_type                  cmd;
   logic signed [KEY_W-1:0]  key;
   logic        [DATA_W-1:0] data_value;
   logic signed [KEY_W-1:0]  new_key;

   modport source (output valid, output cmd, output key, output data_value,
                   output new_key, input ready);
   modport sink   (input valid, input cmd, input key, input data_value,
                   input new_key, output ready);
endinterface

interface lkvt_rsp_if;
   import lkvt_pkg::*;

   logic                      valid;
   logic                      ready;
   logic        [DATA_W-1:0]  read_value;
   status_type                status;
   logic        [COUNT_W-1:0] fill_count;

   modport source (output valid, output read_value, output status,
                   output fill_count, input ready);
   modport sink   (input valid, input read_value, input status,
                   input fill_count, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/linear_key_value_table_unit.sv -----
// Linear key/value table: an unsorted array of key/value pairs with a fill count.
// Depends on lkvt_pkg and the channel interfaces in lkvt_if.sv.
//
// Usage. A request on req_chan carries a command (set, get, take or rename), a key,
// a data value and a new key; exactly one response follows on rsp_chan with the read
// value, a status (done, key not found, set dropped because full) and the fill count
// after the operation. The user must write the miss value for a get or take that finds
// nothing through csr_wr_en/csr_wr_data only while the block is idle (not enforced).
//
// Sequencing. One request is handled at a time. The key store has one registered read
// port, so the lookup walks the occupied entries one per cycle, lowest index first,
// and stops at the first match. The command is then executed; a get hit then reads
// the value, and a take hit reads the value and moves the last entry into the freed
// slot, before the response shows. The next request is taken only once the response
// has been accepted; req_chan.ready is high only while idle.
//
// Reset clears the fill count, the miss value and the sequencer; the key and value
// stores are not cleared, as only entries below the fill count are read. When the
// receiver stalls, the response is held in its registers and no request is taken.
`default_nettype none

module linear_key_value_table_unit #(
   parameter int unsigned ENTRIES     = lkvt_pkg::DEF_ENTRIES,
   parameter int unsigned VALUE_WIDTH = lkvt_pkg::DEF_VALUE_WIDTH
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   lkvt_req_if.sink                         req_chan,
   lkvt_rsp_if.source                       rsp_chan,
   input  wire logic                        csr_wr_en,
   input  wire logic [lkvt_pkg::DATA_W-1:0] csr_wr_data
);
   import lkvt_pkg::*;

   // Index width addresses the stores; count width also holds ENTRIES itself.
   localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int unsigned CNT_W = $clog2(ENTRIES + 1);

   // Sequencer and control state.
   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   scan_ff, scan_in;
   logic               pend_ff, pend_in;
   logic [IDX_W-1:0]   cmp_idx_ff, cmp_idx_in;
   logic               hit_ff, hit_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [DATA_W-1:0]  miss_value_ff;

   // Latched request and response payload.
   cmd_type            cmd_ff, cmd_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [VALUE_WIDTH-1:0] data_ff, data_in;
   logic [KEY_W-1:0]   new_key_ff, new_key_in;
   logic [DATA_W-1:0]  rsp_value_ff, rsp_value_in;
   status_type         rsp_status_ff, rsp_status_in;

   // Store ports: one write and one registered read per store.
   logic [KEY_W-1:0]       key_store [ENTRIES];
   logic [VALUE_WIDTH-1:0] value_store [ENTRIES];
   logic                   key_we, val_we;
   logic [IDX_W-1:0]       key_wa, val_wa, key_ra, val_ra;
   logic [KEY_W-1:0]       key_wd;
   logic [VALUE_WIDTH-1:0] val_wd;
   logic [KEY_W-1:0]       key_rd_ff;
   logic [VALUE_WIDTH-1:0] val_rd_ff;

   logic                   can_issue;
   logic                   match;
   logic                   full;
   logic [CNT_W-1:0]       last_cnt;

   assign can_issue = scan_ff < count_ff;
   assign match     = pend_ff && (key_rd_ff == key_ff);
   assign full      = count_ff == CNT_W'(ENTRIES);
   assign last_cnt  = count_ff - CNT_W'(1);

   always_ff @(posedge clock) begin
      if (key_we) begin
         key_store[key_wa] <= key_wd;
      end
      key_rd_ff <= key_store[key_ra];
   end

   always_ff @(posedge clock) begin
      if (val_we) begin
         value_store[val_wa] <= val_wd;
      end
      val_rd_ff <= value_store[val_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= FSM_IDLE;
         count_ff      <= '0;
         scan_ff       <= '0;
         pend_ff       <= 1'b0;
         hit_ff        <= 1'b0;
         miss_value_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         scan_ff  <= scan_in;
         pend_ff  <= pend_in;
         hit_ff   <= hit_in;
         if (csr_wr_en) begin
            miss_value_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmp_idx_ff    <= cmp_idx_in;
      idx_ff        <= idx_in;
      cmd_ff        <= cmd_in;
      key_ff        <= key_in;
      data_ff       <= data_in;
      new_key_ff    <= new_key_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      scan_in       = scan_ff;
      pend_in       = 1'b0;
      cmp_idx_in    = cmp_idx_ff;
      hit_in        = hit_ff;
      idx_in        = idx_ff;
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      data_in       = data_ff;
      new_key_in    = new_key_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      key_we        = 1'b0;
      val_we        = 1'b0;
      key_wa        = idx_ff;
      val_wa        = idx_ff;
      key_wd        = new_key_ff;
      val_wd        = data_ff;
      key_ra        = '0;
      val_ra        = '0;
      req_chan.ready = 1'b0;
      rsp_chan.valid = 1'b0;

      unique case (state_ff)
         FSM_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               cmd_in     = req_chan.cmd;
               key_in     = req_chan.key;
               data_in    = VALUE_WIDTH'(req_chan.data_value);
               new_key_in = req_chan.new_key;
               scan_in    = '0;
               state_in   = FSM_SCAN;
            end
         end

         // One key is fetched per cycle; the key fetched in the previous cycle
         // is compared against the request key at the same time.
         FSM_SCAN: begin
            if (match) begin
               hit_in   = 1'b1;
               idx_in   = cmp_idx_ff;
               state_in = FSM_EXEC;
            end else if (!can_issue) begin
               hit_in   = 1'b0;
               state_in = FSM_EXEC;
            end else begin
               key_ra     = scan_ff[IDX_W-1:0];
               pend_in    = 1'b1;
               cmp_idx_in = scan_ff[IDX_W-1:0];
               scan_in    = scan_ff + CNT_W'(1);
            end
         end

         FSM_EXEC: begin
            rsp_value_in  = '0;
            rsp_status_in = STS_DONE;
            state_in      = FSM_RESP;
            unique case (cmd_ff)
               CMD_SET: begin
                  if (hit_ff) begin
                     val_we = 1'b1;
                  end else if (!full) begin
                     // Append at the end of the occupied region.
                     key_we   = 1'b1;
                     key_wa   = count_ff[IDX_W-1:0];
                     key_wd   = key_ff;
                     val_we   = 1'b1;
                     val_wa   = count_ff[IDX_W-1:0];
                     count_in = count_ff + CNT_W'(1);
                  end else begin
                     rsp_status_in = STS_FULL;
                  end
               end
               CMD_GET, CMD_TAKE: begin
                  if (hit_ff) begin
                     val_ra   = idx_ff;
                     state_in = (cmd_ff == CMD_GET) ? FSM_GET_VAL : FSM_TAKE_LAST;
                  end else begin
                     rsp_value_in  = miss_value_ff;
                     rsp_status_in = STS_MISS;
                  end
               end
               CMD_RENAME: begin
                  if (hit_ff) begin
                     key_we = 1'b1;
                  end else begin
                     rsp_status_in = STS_MISS;
                  end
               end
               default: begin
                  rsp_status_in = STS_MISS;
               end
            endcase
         end

         FSM_GET_VAL: begin
            rsp_value_in = DATA_W'(val_rd_ff);
            state_in     = FSM_RESP;
         end

         // The taken value is captured while the last entry is fetched.
         FSM_TAKE_LAST: begin
            rsp_value_in = DATA_W'(val_rd_ff);
            key_ra       = last_cnt[IDX_W-1:0];
            val_ra       = last_cnt[IDX_W-1:0];
            state_in     = FSM_TAKE_MOVE;
         end

         // The last entry fills the freed slot; when the taken entry was the
         // last one this rewrites a slot that is no longer occupied.
         FSM_TAKE_MOVE: begin
            key_we   = 1'b1;
            key_wd   = key_rd_ff;
            val_we   = 1'b1;
            val_wd   = val_rd_ff;
            count_in = last_cnt;
            state_in = FSM_RESP;
         end

         FSM_RESP: begin
            rsp_chan.valid = 1'b1;
            if (rsp_chan.ready) begin
               state_in = FSM_IDLE;
            end
         end

         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   assign rsp_chan.read_value = rsp_value_ff;
   assign rsp_chan.status     = rsp_status_ff;
   assign rsp_chan.fill_count = COUNT_W'(count_ff);

endmodule

`default_nettype wire

// ----- rtl/core/lkvt_checker.sv -----
// Port-level assertions for the linear key/value table unit, and their bind.
// Depends on lkvt_pkg; attaches to linear_key_value_table_unit.
`default_nettype none

module lkvt_checker #(
   parameter int unsigned ENTRIES = lkvt_pkg::DEF_ENTRIES
) (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         req_valid,
   input wire logic                         req_ready,
   input wire logic                         rsp_valid,
   input wire logic                         rsp_ready,
   input wire logic [lkvt_pkg::DATA_W-1:0]  rsp_read_value,
   input wire lkvt_pkg::status_type         rsp_status,
   input wire logic [lkvt_pkg::COUNT_W-1:0] rsp_fill_count
);
   import lkvt_pkg::*;

   // A request is being worked on once taken, so the next cycle is never ready.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while the previous one was still in progress");

   // The block never takes a request while a response is outstanding.
   assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request channel ready while a response is pending");

   // A dropped set is only reported when the table is full.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STS_FULL) |-> (rsp_fill_count == COUNT_W'(ENTRIES)))
      else $error("set reported as dropped but the table is not full");

   // A stalled response keeps its data.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_read_value) && $stable(rsp_fill_count)))
      else $error("stalled response changed");

endmodule

bind linear_key_value_table_unit lkvt_checker #(
   .ENTRIES (ENTRIES)
) u_lkvt_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_read_value (rsp_chan.read_value),
   .rsp_status     (rsp_chan.status),
   .rsp_fill_count (rsp_chan.fill_count)
);

`default_nettype wire
